// File: rtl/bba_pkg.sv
// ============================================================================
// bba_pkg
// Shared types and constants of the buddy block allocator.
// ============================================================================
package bba_pkg;

    localparam int MAX_ORDER_DEF     = 16;
    localparam int GRANULE_ORDER_DEF = 5;
    localparam int HEADER_BYTES_DEF  = 32;
    localparam int INIT_ORDER_DEF    = 6;

    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 16;
    localparam int BYTES_W  = 16;
    localparam int ADDR_W   = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] MAX_POOL_RESET = 5'd16;

    localparam logic [MODE_W-1:0] MODE_ALLOC      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC_ZERO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE       = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FREED     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ZERO_SIZE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_MEMORY = 2'd3;

    // datapath commands issued by the controller
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_IDLE,
        CMD_CLEAR,
        CMD_MUL,
        CMD_SIZE,
        CMD_ZERO,
        CMD_LOG,
        CMD_SRCH,
        CMD_GROW,
        CMD_FAIL,
        CMD_TAKE,
        CMD_RMUPD,
        CMD_SPLIT,
        CMD_AFIN,
        CMD_FCHK,
        CMD_FUO,
        CMD_MRD,
        CMD_MTAKE,
        CMD_MNEXT,
        CMD_FPUSH,
        CMD_SHRINK,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic accepted;
        logic in_alloc;
        logic in_free;
        logic prod_zero;
        logic log_stop;
        logic srch_stop;
        logic list_j_filled;
        logic grow_fail;
        logic free_op;
        logic split_more;
        logic free_bad;
        logic fuo_bad;
        logic merge_more;
        logic merge_ok;
        logic shrink_go;
        logic shrink_last;
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/bba_channels.sv
// ============================================================================
// bba channels
// Request and response word channels with valid/ready handshake.
// ============================================================================
interface bba_req_if import bba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] item_count;
    logic [BYTES_W-1:0] item_bytes;
    logic [ADDR_W-1:0]  free_address;

    modport source (output valid, mode, item_count, item_bytes, free_address, input ready);
    modport sink   (input valid, mode, item_count, item_bytes, free_address, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   data_address;
    logic                clear_needed;

    modport source (output valid, status, data_address, clear_needed, input ready);
    modport sink   (input valid, status, data_address, clear_needed, output ready);
endinterface

// File: rtl/bba_datapath.sv
// ============================================================================
// bba_datapath
// Pool state, free lists, granule metadata memories and result registers.
// ============================================================================
module bba_datapath import bba_pkg::*; #(
    parameter int MAX_ORDER     = MAX_ORDER_DEF,
    parameter int GRANULE_ORDER = GRANULE_ORDER_DEF,
    parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
    parameter int INIT_ORDER    = INIT_ORDER_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output dp_status_t       st,
    bba_req_if.sink          req,
    bba_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int GW     = MAX_ORDER - GRANULE_ORDER;
    localparam int GW1    = GW + 1;
    localparam int NGRAN  = 1 << GW;
    localparam int NLIST  = MAX_ORDER + 1;
    localparam int OW     = $clog2(MAX_ORDER + 2);
    localparam int LIW    = $clog2(NLIST);
    localparam int PROD_W = COUNT_W + BYTES_W;
    localparam int PW     = PROD_W + 1;

    localparam logic [32:0]   NGRAN_L   = 33'(NGRAN);
    localparam logic [OW-1:0] ORD_MAX   = OW'(MAX_ORDER);
    localparam logic [OW-1:0] ORD_LIMIT = OW'(MAX_ORDER + 1);
    localparam logic [OW-1:0] ORD_GRAN  = OW'(GRANULE_ORDER);
    localparam logic [OW-1:0] ORD_INIT  = OW'(INIT_ORDER);

    // granules covered by a block of order k
    function automatic logic [GW:0] gspan(input logic [OW-1:0] k);
        logic [OW-1:0] kk;
        logic [GW:0]   s;
        kk = (k > ORD_MAX) ? ORD_MAX : k;
        if (kk <= ORD_GRAN)
            s = GW1'(1);
        else
            s = GW1'(1) << (kk - ORD_GRAN);
        return s;
    endfunction

    function automatic logic [LIW-1:0] li(input logic [OW-1:0] k);
        return k[LIW-1:0];
    endfunction

    // request and pool registers
    logic [MODE_W-1:0]   mode_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [BYTES_W-1:0]  sz_reg;
    logic [ADDR_W-1:0]   fa_reg;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [PW-1:0]       ym1_reg, ym1_next;
    logic [OW-1:0]       p_reg, p_next;
    logic [OW-1:0]       sp_reg, sp_next;
    logic [OW-1:0]       j_reg, j_next;
    logic [OW-1:0]       k_reg, k_next;
    logic [OW-1:0]       rm_k_reg, rm_k_next;
    logic [OW-1:0]       po_reg, po_next;
    logic [GW-1:0]       g_reg, g_next;
    logic [GW-1:0]       bud_reg, bud_next;
    logic [GW-1:0]       rm_g_reg, rm_g_next;
    logic                active_reg, active_next;
    logic [CFG_W-1:0]    maxpo_reg;
    logic [NLIST-1:0]    filled_reg, filled_next;
    logic [GW-1:0]       head_reg [NLIST];
    logic [GW-1:0]       head_next [NLIST];
    logic [GW-1:0]       tail_reg [NLIST];
    logic [GW-1:0]       tail_next [NLIST];
    logic [GW-1:0]       clr_reg, clr_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic                res_clr_reg, res_clr_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic                out_clr_reg;
    logic                out_valid_reg;

    // metadata memories: {used, order}, next link, previous link
    logic [OW:0]   uo_mem [NGRAN];
    logic [GW-1:0] nx_mem [NGRAN];
    logic [GW-1:0] pv_mem [NGRAN];
    logic [OW:0]   uo_rd_reg;
    logic [GW-1:0] nx_rd_reg;
    logic [GW-1:0] pv_rd_reg;

    logic          uo_we, uo_re, nx_we, pv_we, lk_re;
    logic [GW-1:0] uo_wa, uo_ra, nx_wa, pv_wa, lk_ra;
    logic [OW:0]   uo_wd;
    logic [GW-1:0] nx_wd, pv_wd;

    logic          push_en;
    logic [OW-1:0] push_k;
    logic [GW-1:0] push_g;

    logic          accepted;
    logic          uo_used;
    logic [OW-1:0] uo_ord;
    logic [OW-1:0] jm1, pom1;
    logic [GW:0]   gs_po, gs_k, gs_jm1, gs_pom1, gs_ord;
    logic [GW-1:0] split_g, budm, shr_b, shr_bud, rm_head, rm_tail;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] gf;
    logic [31:0]   addr_full;

    assign accepted  = req.valid && req.ready;
    assign req.ready = (cmd == CMD_IDLE);

    assign uo_used  = uo_rd_reg[OW];
    assign uo_ord   = uo_rd_reg[OW-1:0];
    assign jm1      = j_reg - 1'b1;
    assign pom1     = po_reg - 1'b1;
    assign gs_po    = gspan(po_reg);
    assign gs_k     = gspan(k_reg);
    assign gs_jm1   = gspan(jm1);
    assign gs_pom1  = gspan(pom1);
    assign gs_ord   = gspan(uo_ord);
    assign split_g  = g_reg + gs_jm1[GW-1:0];
    assign budm     = g_reg ^ gs_k[GW-1:0];
    assign shr_b    = head_reg[li(pom1)];
    assign shr_bud  = shr_b ^ gs_pom1[GW-1:0];
    assign rm_head  = head_reg[li(rm_k_reg)];
    assign rm_tail  = tail_reg[li(rm_k_reg)];
    assign off      = fa_reg - ADDR_W'(HEADER_BYTES);
    assign gf       = off >> GRANULE_ORDER;
    assign addr_full = (32'(g_reg) << GRANULE_ORDER) + 32'(HEADER_BYTES);

    // status toward the controller
    always_comb
    begin
        st.accepted      = accepted;
        st.in_alloc      = (req.mode == MODE_ALLOC) || (req.mode == MODE_ALLOC_ZERO);
        st.in_free       = (req.mode == MODE_FREE);
        st.prod_zero     = (prod_reg == '0);
        st.log_stop      = (p_reg == ORD_LIMIT) || ((ym1_reg >> p_reg) == '0);
        st.list_j_filled = filled_reg[li(j_reg)];
        st.srch_stop     = !(j_reg < po_reg) || filled_reg[li(j_reg)];
        st.grow_fail     = (32'(po_reg) >= 32'(maxpo_reg)) || (32'(po_reg) >= 32'(MAX_ORDER));
        st.free_op       = (mode_reg == MODE_FREE);
        st.split_more    = (j_reg > sp_reg);
        st.free_bad      = (fa_reg == '0) || !active_reg
                        || (fa_reg < ADDR_W'(HEADER_BYTES))
                        || (off[GRANULE_ORDER-1:0] != '0)
                        || (gf == '0)
                        || (33'(gf) >= 33'(gs_po))
                        || (33'(gf) >= NGRAN_L);
        st.fuo_bad       = !uo_used || (uo_ord >= po_reg)
                        || ((g_reg & (gs_ord[GW-1:0] - 1'b1)) != '0)
                        || ((GW1'(g_reg) + gs_ord) > gs_po);
        st.merge_more    = (k_reg < po_reg);
        st.merge_ok      = !uo_used && (uo_ord == k_reg);
        st.shrink_go     = (po_reg != '0) && filled_reg[li(pom1)] && !(shr_b < shr_bud);
        st.shrink_last   = (pom1 <= ORD_INIT);
        st.clear_last    = (clr_reg == '1);
        st.out_free      = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        prod_next       = prod_reg;
        ym1_next        = ym1_reg;
        p_next          = p_reg;
        sp_next         = sp_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        rm_k_next       = rm_k_reg;
        po_next         = po_reg;
        g_next          = g_reg;
        bud_next        = bud_reg;
        rm_g_next       = rm_g_reg;
        active_next     = active_reg;
        filled_next     = filled_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_clr_next    = res_clr_reg;
        uo_we = 1'b0; uo_wa = '0; uo_wd = '0;
        uo_re = 1'b0; uo_ra = '0;
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
        lk_re = 1'b0; lk_ra = '0;
        push_en = 1'b0;
        push_k  = po_reg;
        push_g  = g_reg;

        unique case (cmd)
            CMD_CLEAR:
            begin
                uo_we = 1'b1; uo_wa = clr_reg;
                nx_we = 1'b1; nx_wa = clr_reg;
                pv_we = 1'b1; pv_wa = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            CMD_IDLE:
            begin
                if (accepted)
                begin
                    res_status_next = STAT_FREED;
                    res_addr_next   = '0;
                    res_clr_next    = 1'b0;
                end
            end
            CMD_MUL:
            begin
                prod_next = cnt_reg * sz_reg;
            end
            CMD_SIZE:
            begin
                ym1_next = PW'(prod_reg) + PW'(HEADER_BYTES - 1);
                p_next   = ORD_GRAN;
                if (!active_reg)
                begin
                    // fresh pool: reserved first block is used
                    filled_next = '0;
                    po_next     = ORD_INIT;
                    active_next = 1'b1;
                    uo_we = 1'b1; uo_wa = '0; uo_wd = {1'b1, ORD_INIT};
                end
            end
            CMD_ZERO:
            begin
                res_status_next = STAT_ZERO_SIZE;
            end
            CMD_LOG:
            begin
                if (st.log_stop)
                begin
                    sp_next = p_reg;
                    j_next  = (p_reg > ORD_MAX) ? ORD_MAX : p_reg;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
            end
            CMD_SRCH:
            begin
                if (!st.srch_stop)
                    j_next = j_reg + 1'b1;
            end
            CMD_GROW:
            begin
                // new upper half becomes a free block of the old pool order
                uo_we = 1'b1; uo_wa = gs_po[GW-1:0]; uo_wd = {1'b0, po_reg};
                push_en = 1'b1; push_k = po_reg; push_g = gs_po[GW-1:0];
                po_next = po_reg + 1'b1;
            end
            CMD_FAIL:
            begin
                res_status_next = STAT_NO_MEMORY;
            end
            CMD_TAKE:
            begin
                rm_g_next = tail_reg[li(j_reg)];
                rm_k_next = j_reg;
                g_next    = tail_reg[li(j_reg)];
                lk_re = 1'b1; lk_ra = tail_reg[li(j_reg)];
            end
            CMD_RMUPD:
            begin
                if (filled_reg[li(rm_k_reg)])
                begin
                    priority if (rm_head == rm_tail)
                        filled_next[li(rm_k_reg)] = 1'b0;
                    else if (rm_g_reg == rm_head)
                        head_next[li(rm_k_reg)] = nx_rd_reg;
                    else if (rm_g_reg == rm_tail)
                        tail_next[li(rm_k_reg)] = pv_rd_reg;
                    else
                    begin
                        nx_we = 1'b1; nx_wa = pv_rd_reg; nx_wd = nx_rd_reg;
                        pv_we = 1'b1; pv_wa = nx_rd_reg; pv_wd = pv_rd_reg;
                    end
                end
            end
            CMD_SPLIT:
            begin
                j_next = jm1;
                uo_we = 1'b1; uo_wa = split_g; uo_wd = {1'b0, jm1};
                push_en = 1'b1; push_k = jm1; push_g = split_g;
            end
            CMD_AFIN:
            begin
                uo_we = 1'b1; uo_wa = g_reg; uo_wd = {1'b1, sp_reg};
                res_status_next = STAT_ALLOCATED;
                res_addr_next   = addr_full[ADDR_W-1:0];
                res_clr_next    = (mode_reg == MODE_ALLOC_ZERO);
            end
            CMD_FCHK:
            begin
                g_next = GW'(gf);
                uo_re = 1'b1; uo_ra = GW'(gf);
            end
            CMD_FUO:
            begin
                k_next = uo_ord;
            end
            CMD_MRD:
            begin
                bud_next = budm;
                uo_re = 1'b1; uo_ra = budm;
            end
            CMD_MTAKE:
            begin
                rm_g_next = bud_reg;
                rm_k_next = k_reg;
                lk_re = 1'b1; lk_ra = bud_reg;
            end
            CMD_MNEXT:
            begin
                k_next = k_reg + 1'b1;
                if (bud_reg < g_reg)
                    g_next = bud_reg;
            end
            CMD_FPUSH:
            begin
                uo_we = 1'b1; uo_wa = g_reg; uo_wd = {1'b0, k_reg};
                push_en = 1'b1; push_k = k_reg; push_g = g_reg;
            end
            CMD_SHRINK:
            begin
                filled_next[li(po_reg)] = 1'b0;
                filled_next[li(pom1)]   = 1'b0;
                po_next = pom1;
                if (st.shrink_last)
                    active_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        // push to list head
        if (push_en)
        begin
            if (!filled_reg[li(push_k)])
            begin
                head_next[li(push_k)]   = push_g;
                tail_next[li(push_k)]   = push_g;
                filled_next[li(push_k)] = 1'b1;
            end
            else
            begin
                nx_we = 1'b1; nx_wa = push_g; nx_wd = head_reg[li(push_k)];
                pv_we = 1'b1; pv_wa = head_reg[li(push_k)]; pv_wd = push_g;
                head_next[li(push_k)] = push_g;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            po_reg        <= ORD_INIT;
            active_reg    <= 1'b0;
            filled_reg    <= '0;
            maxpo_reg     <= MAX_POOL_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            po_reg     <= po_next;
            active_reg <= active_next;
            filled_reg <= filled_next;
            clr_reg    <= clr_next;
            if (cfg_we)
                maxpo_reg <= cfg_wdata;
            if (cmd == CMD_EMIT)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            mode_reg <= req.mode;
            cnt_reg  <= req.item_count;
            sz_reg   <= req.item_bytes;
            fa_reg   <= req.free_address;
        end
        prod_reg       <= prod_next;
        ym1_reg        <= ym1_next;
        p_reg          <= p_next;
        sp_reg         <= sp_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        rm_k_reg       <= rm_k_next;
        g_reg          <= g_next;
        bud_reg        <= bud_next;
        rm_g_reg       <= rm_g_next;
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_clr_reg    <= res_clr_next;
        if (cmd == CMD_EMIT)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_clr_reg    <= res_clr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uo_we)
            uo_mem[uo_wa] <= uo_wd;
        if (uo_re)
            uo_rd_reg <= uo_mem[uo_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
            nx_mem[nx_wa] <= nx_wd;
        if (lk_re)
            nx_rd_reg <= nx_mem[lk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
            pv_mem[pv_wa] <= pv_wd;
        if (lk_re)
            pv_rd_reg <= pv_mem[lk_ra];
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.data_address = out_addr_reg;
    assign rsp.clear_needed = out_clr_reg;

endmodule

// File: rtl/bba_controller.sv
// ============================================================================
// bba_controller
// Sequencer for memory clear, allocate and free flows.
// ============================================================================
module bba_controller import bba_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t st,
    output cmd_t       cmd
);

    typedef enum logic [16:0] {
        S_CLEAR  = 17'h00001,
        S_IDLE   = 17'h00002,
        S_MUL    = 17'h00004,
        S_SIZE   = 17'h00008,
        S_LOG    = 17'h00010,
        S_SRCH   = 17'h00020,
        S_GROW   = 17'h00040,
        S_TAKE   = 17'h00080,
        S_RMUPD  = 17'h00100,
        S_SPLIT  = 17'h00200,
        S_FCHK   = 17'h00400,
        S_FUO    = 17'h00800,
        S_MRD    = 17'h01000,
        S_MCHK   = 17'h02000,
        S_MNEXT  = 17'h04000,
        S_SHRINK = 17'h08000,
        S_DONE   = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd = CMD_CLEAR;
                if (st.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd = CMD_IDLE;
                if (st.accepted)
                begin
                    priority if (st.in_alloc)
                        state_next = S_MUL;
                    else if (st.in_free)
                        state_next = S_FCHK;
                    else
                        state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                cmd        = CMD_MUL;
                state_next = S_SIZE;
            end
            S_SIZE:
            begin
                if (st.prod_zero)
                begin
                    cmd        = CMD_ZERO;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_SIZE;
                    state_next = S_LOG;
                end
            end
            S_LOG:
            begin
                cmd = CMD_LOG;
                if (st.log_stop)
                    state_next = S_SRCH;
            end
            S_SRCH:
            begin
                cmd = CMD_SRCH;
                if (st.srch_stop)
                    state_next = S_GROW;
            end
            S_GROW:
            begin
                priority if (st.list_j_filled)
                    state_next = S_TAKE;
                else if (st.grow_fail)
                begin
                    cmd        = CMD_FAIL;
                    state_next = S_DONE;
                end
                else
                    cmd = CMD_GROW;
            end
            S_TAKE:
            begin
                cmd        = CMD_TAKE;
                state_next = S_RMUPD;
            end
            S_RMUPD:
            begin
                cmd        = CMD_RMUPD;
                state_next = st.free_op ? S_MNEXT : S_SPLIT;
            end
            S_SPLIT:
            begin
                if (st.split_more)
                    cmd = CMD_SPLIT;
                else
                begin
                    cmd        = CMD_AFIN;
                    state_next = S_DONE;
                end
            end
            S_FCHK:
            begin
                cmd        = CMD_FCHK;
                state_next = st.free_bad ? S_DONE : S_FUO;
            end
            S_FUO:
            begin
                cmd        = CMD_FUO;
                state_next = st.fuo_bad ? S_DONE : S_MRD;
            end
            S_MRD:
            begin
                if (st.merge_more)
                begin
                    cmd        = CMD_MRD;
                    state_next = S_MCHK;
                end
                else
                begin
                    cmd        = CMD_FPUSH;
                    state_next = S_SHRINK;
                end
            end
            S_MCHK:
            begin
                if (st.merge_ok)
                begin
                    cmd        = CMD_MTAKE;
                    state_next = S_RMUPD;
                end
                else
                begin
                    cmd        = CMD_FPUSH;
                    state_next = S_SHRINK;
                end
            end
            S_MNEXT:
            begin
                cmd        = CMD_MNEXT;
                state_next = S_MRD;
            end
            S_SHRINK:
            begin
                if (st.shrink_go)
                begin
                    cmd = CMD_SHRINK;
                    if (st.shrink_last)
                        state_next = S_DONE;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/buddy_block_allocator.sv
// ============================================================================
// buddy_block_allocator
// Binary buddy allocator over a pool that grows and shrinks by doubling.
// ============================================================================
// req carries one word per request: mode (allocate, allocate zeroed, free),
// item_count, item_bytes and free_address. rsp returns one word per request:
// status, data_address and clear_needed. cfg_we/cfg_wdata set the pool order
// limit; write it only while the block is idle.
// One request is in flight at a time; req is ready only in the idle state,
// which is entered as the previous word is loaded into rsp. An allocate
// walks up to the needed order, searches the free lists, doubles the pool
// when no list holds a block and splits the block taken; a free checks the
// address, merges with free buddies and halves the pool where it can.
// After reset the metadata RAMs are swept to zero, one granule per cycle
// over all 2^(MAX_ORDER-GRANULE_ORDER) granules, 2048 by default; req is not
// ready until then. If rsp stalls, the next finished word waits in the result
// registers until the rsp register frees, and req stays not ready meanwhile.
// ============================================================================
module buddy_block_allocator import bba_pkg::*; #(
    parameter int MAX_ORDER     = MAX_ORDER_DEF,
    parameter int GRANULE_ORDER = GRANULE_ORDER_DEF,
    parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
    parameter int INIT_ORDER    = INIT_ORDER_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    bba_req_if.sink          req,
    bba_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    cmd_t       cmd;
    dp_status_t st;

    bba_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    bba_datapath #(
        .MAX_ORDER     (MAX_ORDER),
        .GRANULE_ORDER (GRANULE_ORDER),
        .HEADER_BYTES  (HEADER_BYTES),
        .INIT_ORDER    (INIT_ORDER)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// File: tb/tb_buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// Self-checking bench: drives allocate, free and unused-mode requests with random gaps and
// backpressure, predicts every response word in a scoreboard class and
// compares status, data_address and clear_needed field by field.
// ----------------------------------------------------------------------------
import bba_pkg::*;

typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic                clr;
} rsp_word_t;

class alloc_scoreboard;
    localparam int unsigned MAXO  = MAX_ORDER_DEF;
    localparam int unsigned GRO   = GRANULE_ORDER_DEF;
    localparam int unsigned HDR   = HEADER_BYTES_DEF;
    localparam int unsigned INITO = INIT_ORDER_DEF;
    localparam int unsigned NGRAN = 1 << (MAXO - GRO);
    localparam int unsigned GMASK = NGRAN - 1;

    bit          gran_used[NGRAN];
    int unsigned gran_ord[NGRAN];
    int unsigned nxt[NGRAN];
    int unsigned prv[NGRAN];
    int unsigned head[MAXO+1];
    int unsigned tail[MAXO+1];
    bit          filled[MAXO+1];
    int unsigned pool_ord;
    bit          pool_on;
    int unsigned limit_ord;
    rsp_word_t   pending[$];
    int          errors;

    function new();
        foreach (gran_used[i])
        begin
            gran_used[i] = 0;
            gran_ord[i]  = 0;
            nxt[i]       = 0;
            prv[i]       = 0;
        end
        foreach (filled[i])
        begin
            filled[i] = 0;
            head[i]   = 0;
            tail[i]   = 0;
        end
        pool_ord  = INITO;
        pool_on   = 0;
        limit_ord = MAX_POOL_RESET;
        errors    = 0;
    endfunction

    function int unsigned span_of(int unsigned k);
        if (k <= GRO)
            return 1;
        if (k > MAXO)
            k = MAXO;
        return 1 << (k - GRO);
    endfunction

    function void push_head(int unsigned k, int unsigned g);
        g &= GMASK;
        if (!filled[k])
        begin
            head[k]   = g;
            tail[k]   = g;
            filled[k] = 1;
        end
        else
        begin
            nxt[g] = head[k];
            prv[head[k] & GMASK] = g;
            head[k] = g;
        end
    endfunction

    function void unlink(int unsigned k, int unsigned g);
        g &= GMASK;
        if (!filled[k])
            return;
        if (head[k] == tail[k])
            filled[k] = 0;
        else if (g == head[k])
            head[k] = nxt[g] & GMASK;
        else if (g == tail[k])
            tail[k] = prv[g] & GMASK;
        else
        begin
            nxt[prv[g] & GMASK] = nxt[g];
            prv[nxt[g] & GMASK] = prv[g];
        end
    endfunction

    function int unsigned order_for(longint unsigned x);
        int unsigned p;
        p = 0;
        while (p < 63 && ((64'd1 << p) < x))
            p++;
        return p;
    endfunction

    function logic [STATUS_W-1:0] grab(longint unsigned nbytes, output int unsigned addr);
        int unsigned sp, j, l, nb, p;
        addr = 0;
        if (!pool_on)
        begin
            foreach (filled[i])
                filled[i] = 0;
            pool_ord     = INITO;
            pool_on      = 1;
            gran_used[0] = 1;
            gran_ord[0]  = INITO;
        end
        sp = order_for(longint'(HDR) + nbytes);
        if (sp < GRO)
            sp = GRO;
        j = (sp > MAXO) ? MAXO : sp;
        while (j < pool_ord && !filled[j])
            j++;
        while (!filled[j])
        begin
            if (pool_ord >= limit_ord || pool_ord >= MAXO)
                return STAT_NO_MEMORY;
            nb = span_of(pool_ord) & GMASK;
            gran_used[nb] = 0;
            gran_ord[nb]  = pool_ord;
            push_head(pool_ord, nb);
            pool_ord++;
        end
        l = tail[j] & GMASK;
        unlink(j, l);
        gran_used[l] = 1;
        while (j > sp)
        begin
            j--;
            p = (l + span_of(j)) & GMASK;
            gran_used[p] = 0;
            gran_ord[p]  = j;
            push_head(j, p);
        end
        gran_ord[l] = sp;
        addr = (l << GRO) + HDR;
        return STAT_ALLOCATED;
    endfunction

    function void release_block(int unsigned fa);
        int unsigned off, g, k, span, pspan, bud, b;
        if (fa == 0 || !pool_on || fa < HDR)
            return;
        off = fa - HDR;
        if ((off & ((1 << GRO) - 1)) != 0)
            return;
        g = off >> GRO;
        pspan = span_of(pool_ord);
        if (g == 0 || g >= pspan || g >= NGRAN)
            return;
        if (!gran_used[g])
            return;
        k = gran_ord[g];
        if (k >= pool_ord)
            return;
        span = span_of(k);
        if ((g & (span - 1)) != 0 || g + span > pspan)
            return;
        // merge upward with free buddies of equal order
        while (k < pool_ord)
        begin
            bud = (g ^ span_of(k)) & GMASK;
            if (gran_used[bud] || gran_ord[bud] != k)
                break;
            unlink(k, bud);
            k++;
            if (bud < g)
                g = bud;
        end
        gran_used[g] = 0;
        gran_ord[g]  = k;
        push_head(k, g);
        // shrink while the top half is one free block
        while (pool_ord > 0 && filled[pool_ord-1])
        begin
            b   = head[pool_ord-1] & GMASK;
            bud = b ^ span_of(pool_ord-1);
            if (b < bud)
                break;
            filled[pool_ord] = 0;
            pool_ord--;
            filled[pool_ord] = 0;
            if (pool_ord <= INITO)
            begin
                pool_on = 0;
                break;
            end
        end
    endfunction

    function rsp_word_t note_request(logic [1:0] mode, logic [15:0] cnt,
                                     logic [15:0] nbytes, logic [15:0] fa);
        rsp_word_t       w;
        longint unsigned prod;
        int unsigned     a;
        w.status = STAT_FREED;
        w.addr   = 0;
        w.clr    = 0;
        if (mode == MODE_ALLOC || mode == MODE_ALLOC_ZERO)
        begin
            prod = longint'(cnt) * longint'(nbytes);
            if (prod == 0)
                w.status = STAT_ZERO_SIZE;
            else
            begin
                w.status = grab(prod, a);
                if (w.status == STAT_ALLOCATED)
                begin
                    w.addr = a[15:0];
                    w.clr  = (mode == MODE_ALLOC_ZERO);
                end
            end
        end
        else if (mode == MODE_FREE)
            release_block(fa);
        pending.push_back(w);
        return w;
    endfunction

    function void check_response(logic [1:0] status, logic [15:0] addr, logic clr);
        rsp_word_t w;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected word status=%0d addr=%0d clr=%0d",
                     $time, status, addr, clr);
            errors++;
            return;
        end
        w = pending.pop_front();
        if (status !== w.status)
        begin
            $display("%0t: status exp %0d got %0d", $time, w.status, status);
            errors++;
        end
        if (addr !== w.addr)
        begin
            $display("%0t: data_address exp %0d got %0d", $time, w.addr, addr);
            errors++;
        end
        if (clr !== w.clr)
        begin
            $display("%0t: clear_needed exp %0d got %0d", $time, w.clr, clr);
            errors++;
        end
    endfunction
endclass

module tb_buddy_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 150;

    logic clk = 0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    bba_req_if req ();
    bba_rsp_if rsp ();

    buddy_block_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    alloc_scoreboard sb = new();
    int unsigned live_blocks[$];
    bit calm = 0;
    bit hold_rsp = 0;
    int cycles = 0;

    always #5 clk = ~clk;

    initial
    begin
        rst_n          = 0;
        cfg_we         = 0;
        cfg_wdata      = '0;
        req.valid      = 0;
        req.mode       = MODE_ALLOC;
        req.item_count = '0;
        req.item_bytes = '0;
        req.free_address = '0;
        rsp.ready      = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_response(rsp.status, rsp.data_address, rsp.clear_needed);

    // response side: random stall bursts, one long hold on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_rsp)
            begin
                rsp.ready <= 0;
                repeat (400) @(posedge clk);
                hold_rsp = 0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                rsp.ready <= 0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_word(logic [1:0] mode, logic [15:0] cnt, logic [15:0] nb,
                             logic [15:0] fa);
        rsp_word_t w;
        int idx[$];
        req.valid        <= 1;
        req.mode         <= mode;
        req.item_count   <= cnt;
        req.item_bytes   <= nb;
        req.free_address <= fa;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        w = sb.note_request(mode, cnt, nb, fa);
        if (w.status == STAT_ALLOCATED)
            live_blocks.push_back(w.addr);
        if (mode == MODE_FREE)
        begin
            idx = live_blocks.find_first_index(x) with (x == fa);
            if (idx.size() != 0)
                live_blocks.delete(idx[0]);
        end
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain_and_set_limit(logic [CFG_W-1:0] lim);
        req.valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we    <= 1;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we <= 0;
        sb.limit_ord = lim;
    endtask

    task automatic random_word();
        int unsigned pick, k;
        logic [1:0] m;
        pick = $urandom_range(0, 99);
        m = $urandom_range(0, 1) ? MODE_ALLOC_ZERO : MODE_ALLOC;
        if (pick < 42 && live_blocks.size() != 0)
        begin
            k = $urandom_range(0, live_blocks.size() - 1);
            send_word(MODE_FREE, 16'($urandom), 16'($urandom), 16'(live_blocks[k]));
        end
        else if (pick < 80)
            send_word(m, 16'($urandom_range(1, 4)), 16'($urandom_range(1, 600)),
                      16'($urandom));
        else if (pick < 84)
            send_word(m, 16'($urandom_range(1, 2)), 16'($urandom_range(600, 8000)),
                      16'($urandom));
        else if (pick < 87)
            send_word(m, $urandom_range(0, 1) ? 16'd0 : 16'($urandom),
                      $urandom_range(0, 1) ? 16'($urandom) : 16'd0, 16'($urandom));
        else if (pick < 90)
            send_word(m, 16'($urandom), 16'($urandom), 16'($urandom));
        else if (pick < 95)
            // plausible but bogus frees: granule aligned or fully random
            send_word(MODE_FREE, 16'($urandom), 16'($urandom),
                      $urandom_range(0, 1) ? 16'(($urandom_range(0, 2047) << 5) + 32)
                                           : 16'($urandom));
        else if (pick < 98)
            send_word(MODE_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
        else
            send_word(MODE_FREE, 16'($urandom), 16'($urandom), 16'd0);
    endtask

    initial
    begin
        logic [CFG_W-1:0] limits[6];
        limits = '{5'd16, 5'd7, 5'd31, 5'd10, 5'd0, 5'd16};
        repeat (10) @(posedge clk);
        rst_n <= 1;

        // directed corners
        send_word(MODE_ALLOC, 16'd1, 16'd1, 16'd0);
        send_word(MODE_ALLOC_ZERO, 16'd1, 16'd32, 16'd0);
        send_word(MODE_ALLOC, 16'd0, 16'd100, 16'd0);
        send_word(MODE_ALLOC_ZERO, 16'd100, 16'd0, 16'd0);
        send_word(MODE_ALLOC, 16'd4, 16'd8, 16'd0);
        send_word(MODE_FREE, 16'd0, 16'd0, 16'd0);
        send_word(MODE_FREE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(MODE_FREE, 16'd0, 16'd0, 16'd32);
        send_word(MODE_FREE, 16'd0, 16'd0, 16'd16);
        send_word(MODE_FREE, 16'd0, 16'd0, 16'd97);
        send_word(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'd96);
        send_word(MODE_ALLOC, 16'hFFFF, 16'hFFFF, 16'd0);
        send_word(MODE_ALLOC, 16'd1, 16'd4000, 16'd0);
        send_word(MODE_FREE, 16'd0, 16'd0, 16'(live_blocks[0]));
        send_word(MODE_FREE, 16'd0, 16'd0, 16'd96);
        while (live_blocks.size() != 0)
            send_word(MODE_FREE, 16'd0, 16'd0, 16'(live_blocks[0]));
        send_word(MODE_FREE, 16'd0, 16'd0, 16'd64);

        foreach (limits[p])
        begin
            drain_and_set_limit(limits[p]);
            if (p == 1)
                hold_rsp = 1;
            if (p == 5)
                calm = 1;
            repeat (190)
            begin
                random_word();
                sender_gap();
            end
        end

        req.valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
